/* sv/i2cm_pkg.sv */
`default_nettype none

package i2cm_pkg;

   localparam int unsigned CFG_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned BITS_PER_BYTE = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETUP_TICKS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_TICKS = 1'd1;

   localparam logic [CFG_WIDTH-1:0] SETUP_TICKS_RESET = 16'd40;
   localparam logic [CFG_WIDTH-1:0] HIGH_TICKS_RESET = 16'd16;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ = 2'd3;

   localparam logic [3:0] BIT_COUNT_LAST = 4'd8;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_START_A    = 4'd1,
      PH_START_B    = 4'd2,
      PH_STOP       = 4'd3,
      PH_WR_DATA    = 4'd4,
      PH_WR_HIGH    = 4'd5,
      PH_WR_ACK     = 4'd6,
      PH_RD_HIGH    = 4'd7,
      PH_RD_ACK_SET = 4'd8,
      PH_RD_ACK_HI  = 4'd9
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] opcode;
      logic [7:0] write_byte;
      logic       send_ack;
      logic       scl_level;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_received;
      logic       bus_idle;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] bit_count;
      logic [7:0] shift_reg;
      logic       scl_low;
      logic       sda_low;
      logic       ack_flag;
      logic       ack_seen;
      logic [7:0] read_hold;
   } state_type;

endpackage

`default_nettype wire

/* sv/i2cm_step.sv */
`default_nettype none

module i2cm_step #(
   parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
   input  wire i2cm_pkg::state_type                state_cur,
   input  wire logic [TICK_COUNTER_WIDTH-1:0]      tick_cur,
   input  wire i2cm_pkg::req_type                  item,
   input  wire logic [i2cm_pkg::CFG_WIDTH-1:0]     setup_ticks,
   input  wire logic [i2cm_pkg::CFG_WIDTH-1:0]     high_ticks,
   output i2cm_pkg::state_type                     state_nxt,
   output logic [TICK_COUNTER_WIDTH-1:0]           tick_nxt,
   output i2cm_pkg::rsp_type                       rsp
);

   localparam int unsigned CW = (TICK_COUNTER_WIDTH > i2cm_pkg::CFG_WIDTH) ?
                                TICK_COUNTER_WIDTH : i2cm_pkg::CFG_WIDTH;
   localparam logic [CW-1:0] TICK_MASK = CW'({TICK_COUNTER_WIDTH{1'b1}});

   logic                          use_setup;
   logic [CW-1:0]                 delay_ext;
   logic [CW-1:0]                 limit_ext;
   logic [TICK_COUNTER_WIDTH-1:0] limit;
   logic                          expired;
   logic [TICK_COUNTER_WIDTH-1:0] tick_step;
   logic                          done;
   logic [3:0]                    bit_inc;

   // one shared timer compare, setup delay for start and stop, high time otherwise
   always_comb begin
      use_setup = (state_cur.phase == i2cm_pkg::PH_START_A) ||
                  (state_cur.phase == i2cm_pkg::PH_START_B) ||
                  (state_cur.phase == i2cm_pkg::PH_STOP);
      delay_ext = use_setup ? CW'(setup_ticks) : CW'(high_ticks);
      limit_ext = (delay_ext > TICK_MASK) ? TICK_MASK : delay_ext;
      limit = limit_ext[TICK_COUNTER_WIDTH-1:0];
      expired = (tick_cur >= limit);
      tick_step = expired ? '0 : tick_cur + 1'b1;
   end

   assign bit_inc = state_cur.bit_count + 4'd1;

   always_comb begin
      state_nxt = state_cur;
      tick_nxt = tick_cur;
      done = 1'b0;
      unique case (state_cur.phase)
         i2cm_pkg::PH_IDLE: begin
            if (item.cmd_valid) begin
               tick_nxt = '0;
               unique case (item.opcode)
                  i2cm_pkg::OP_START: begin
                     state_nxt.sda_low = 1'b1;
                     state_nxt.phase = i2cm_pkg::PH_START_A;
                  end
                  i2cm_pkg::OP_STOP: begin
                     state_nxt.scl_low = 1'b0;
                     state_nxt.phase = i2cm_pkg::PH_STOP;
                  end
                  i2cm_pkg::OP_WRITE: begin
                     state_nxt.shift_reg = item.write_byte;
                     state_nxt.bit_count = '0;
                     state_nxt.scl_low = 1'b1;
                     state_nxt.phase = i2cm_pkg::PH_WR_DATA;
                  end
                  default: begin
                     state_nxt.shift_reg = '0;
                     state_nxt.bit_count = '0;
                     state_nxt.ack_flag = item.send_ack;
                     state_nxt.scl_low = 1'b1;
                     state_nxt.sda_low = 1'b0;
                     state_nxt.phase = i2cm_pkg::PH_RD_HIGH;
                  end
               endcase
            end
         end
         i2cm_pkg::PH_START_A: begin
            tick_nxt = tick_step;
            if (expired) begin
               state_nxt.scl_low = 1'b1;
               state_nxt.phase = i2cm_pkg::PH_START_B;
            end
         end
         i2cm_pkg::PH_START_B: begin
            tick_nxt = tick_step;
            if (expired) begin
               done = 1'b1;
               state_nxt.phase = i2cm_pkg::PH_IDLE;
            end
         end
         i2cm_pkg::PH_STOP: begin
            tick_nxt = tick_step;
            if (expired) begin
               state_nxt.sda_low = 1'b0;
               done = 1'b1;
               state_nxt.phase = i2cm_pkg::PH_IDLE;
            end
         end
         i2cm_pkg::PH_WR_DATA: begin
            tick_nxt = '0;
            if (state_cur.bit_count >= i2cm_pkg::BIT_COUNT_LAST) begin
               state_nxt.sda_low = 1'b0;
               state_nxt.phase = i2cm_pkg::PH_WR_ACK;
            end else begin
               state_nxt.sda_low = ~state_cur.shift_reg[7];
               state_nxt.phase = i2cm_pkg::PH_WR_HIGH;
            end
         end
         i2cm_pkg::PH_WR_HIGH: begin
            tick_nxt = tick_step;
            if (expired) begin
               state_nxt.scl_low = 1'b1;
               state_nxt.shift_reg = {state_cur.shift_reg[6:0], 1'b0};
               state_nxt.bit_count = bit_inc;
               state_nxt.phase = i2cm_pkg::PH_WR_DATA;
            end else begin
               state_nxt.scl_low = 1'b0;
            end
         end
         i2cm_pkg::PH_WR_ACK: begin
            // release scl, then wait out clock stretching before sampling ack
            if (tick_cur == '0) begin
               state_nxt.scl_low = 1'b0;
               tick_nxt = TICK_COUNTER_WIDTH'(1);
            end else if (item.scl_level) begin
               state_nxt.ack_seen = ~item.sda_level;
               state_nxt.scl_low = 1'b1;
               state_nxt.sda_low = 1'b1;
               tick_nxt = '0;
               done = 1'b1;
               state_nxt.phase = i2cm_pkg::PH_IDLE;
            end
         end
         i2cm_pkg::PH_RD_HIGH: begin
            tick_nxt = tick_step;
            if (expired) begin
               state_nxt.shift_reg = {state_cur.shift_reg[6:0], item.sda_level};
               state_nxt.scl_low = 1'b1;
               state_nxt.bit_count = bit_inc;
               if (bit_inc >= i2cm_pkg::BIT_COUNT_LAST) begin
                  state_nxt.phase = i2cm_pkg::PH_RD_ACK_SET;
               end
            end else begin
               state_nxt.scl_low = 1'b0;
            end
         end
         i2cm_pkg::PH_RD_ACK_SET: begin
            state_nxt.scl_low = 1'b1;
            state_nxt.sda_low = state_cur.ack_flag;
            tick_nxt = '0;
            state_nxt.phase = i2cm_pkg::PH_RD_ACK_HI;
         end
         i2cm_pkg::PH_RD_ACK_HI: begin
            tick_nxt = tick_step;
            if (expired) begin
               state_nxt.scl_low = 1'b1;
               state_nxt.sda_low = 1'b1;
               state_nxt.read_hold = state_cur.shift_reg;
               done = 1'b1;
               state_nxt.phase = i2cm_pkg::PH_IDLE;
            end else begin
               state_nxt.scl_low = 1'b0;
            end
         end
         default: begin
            state_nxt.phase = i2cm_pkg::PH_IDLE;
            tick_nxt = '0;
         end
      endcase
   end

   always_comb begin
      rsp.scl_drive_low = state_nxt.scl_low;
      rsp.sda_drive_low = state_nxt.sda_low;
      rsp.busy_res = (state_nxt.phase != i2cm_pkg::PH_IDLE);
      rsp.done_res = done;
      rsp.read_data = state_nxt.read_hold;
      rsp.ack_received = state_nxt.ack_seen;
      rsp.bus_idle = item.scl_level & item.sda_level;
   end

endmodule

`default_nettype wire

/* sv/i2c_master_byte_engine.sv */
`default_nettype none

// Open-drain I2C master. Each item is one tick of the bus timer: the sampled
// SCL and SDA levels plus an optional start, stop, write-byte or read-byte
// command, which is only looked at while the engine is idle. Every item gives
// exactly one result: the SCL and SDA pull-down controls, busy, done, the last
// read byte, the last write ACK and whether the bus reads idle. One item is
// taken per clock cycle unless req_stall is high; an item passes an input
// register, the combinational controller step and a result register. A
// stalled result holds the input register and stalls req until the result is
// taken. The user writes setup_ticks and high_ticks through the csr port only
// while no item is in flight; the block itself does not enforce this.
module i2c_master_byte_engine #(
   parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_stall,
   input  wire i2cm_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output i2cm_pkg::rsp_type                           rsp_data,
   input  wire                                         csr_we,
   input  wire logic [i2cm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [i2cm_pkg::CFG_WIDTH-1:0]         csr_wdata
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   i2cm_pkg::req_type                 in_data_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   i2cm_pkg::rsp_type                 rsp_data_ff;
   i2cm_pkg::rsp_type                 rsp_data_in;
   i2cm_pkg::state_type               state_ff;
   i2cm_pkg::state_type               state_in;
   logic [TICK_COUNTER_WIDTH-1:0]     tick_ff;
   logic [TICK_COUNTER_WIDTH-1:0]     tick_in;
   logic [i2cm_pkg::CFG_WIDTH-1:0]    setup_ticks_ff;
   logic [i2cm_pkg::CFG_WIDTH-1:0]    high_ticks_ff;
   logic                              accept;
   logic                              advance;

   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   i2cm_step #(
      .TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
   ) u_step (
      .state_cur   (state_ff),
      .tick_cur    (tick_ff),
      .item        (in_data_ff),
      .setup_ticks (setup_ticks_ff),
      .high_ticks  (high_ticks_ff),
      .state_nxt   (state_in),
      .tick_nxt    (tick_in),
      .rsp         (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= i2cm_pkg::PH_IDLE;
         state_ff.bit_count <= '0;
         state_ff.shift_reg <= '0;
         state_ff.scl_low <= 1'b0;
         state_ff.sda_low <= 1'b0;
         state_ff.ack_flag <= 1'b0;
         state_ff.ack_seen <= 1'b0;
         state_ff.read_hold <= '0;
         tick_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         tick_ff <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ticks_ff <= i2cm_pkg::SETUP_TICKS_RESET;
         high_ticks_ff <= i2cm_pkg::HIGH_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            i2cm_pkg::CSR_SETUP_TICKS: setup_ticks_ff <= csr_wdata;
            i2cm_pkg::CSR_HIGH_TICKS: high_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.done_res && rsp_data_ff.busy_res))
      else $error("done and busy reported together");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_count <= i2cm_pkg::BIT_COUNT_LAST)
      else $error("bit counter past one byte");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.phase == i2cm_pkg::PH_IDLE && !in_data_ff.cmd_valid)
      |=> state_ff.phase == i2cm_pkg::PH_IDLE)
      else $error("left idle without a command");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room downstream");
`endif

endmodule

`default_nettype wire
